// File: design/pbcr_pkg.sv
package pbcr_pkg;

	localparam int NUM_FRAMES = 64;
	localparam int PAGE_BITS = 32;
	localparam int PIN_BITS = 8;
	localparam int IDX_W = $clog2(NUM_FRAMES);
	localparam int CNT_W = IDX_W + 1;
	localparam int STEP_W = IDX_W + 2;
	localparam int CFG_W = 7;
	localparam int REL_W = 6;
	localparam int OIDX_W = 6;
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	localparam int IN_DATA_W = ((PAGE_BITS + REL_W + 7) / 8) * 8;
	localparam int OUT_RAW_W = OIDX_W + 3 + PAGE_BITS;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	typedef enum logic {
		MODE_GET = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

	typedef struct packed {
		logic [PAGE_BITS-1:0] tag;
		logic mark;
		logic [PIN_BITS-1:0] pin;
		logic assigned;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LREAD,
		ST_LEVAL,
		ST_SREAD,
		ST_SEVAL,
		ST_RREAD,
		ST_REVAL,
		ST_OUT
	} state_t;

endpackage

// File: design/page_buffer_clock_replacement.sv
// Frame table of a page buffer with clock (second chance) replacement. A get word
// (tuser 0) first searches frames 0..n-1 in turn, n being frames_in_use clamped to
// 1..64; a hit pins the frame and sets its mark. On a miss the clock hand sweeps,
// clearing marks of unpinned frames until it finds an unpinned unmarked victim,
// which is retagged with one pin and the mark; after 2n looks with no victim
// all_pinned is reported. A release word (tuser 1) drops one pin of release_frame.
// Each frame look is a read state and an evaluate state, since the frame memory
// has a registered read port. One item is in flight at a time. The frame memory
// needs no clearing pass: per-frame valid bits cleared at reset make unwritten
// frames read as empty.
module page_buffer_clock_replacement (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pbcr_pkg::CFG_W-1:0] cfg_data,      // frames_in_use
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [pbcr_pkg::IN_DATA_W-1:0] s_tdata,   // requested page, release_frame
	input  logic s_tuser,                             // mode
	output logic m_tvalid,
	input  logic m_tready,
	output logic [pbcr_pkg::OUT_DATA_W-1:0] m_tdata   // frame_index, hit, evicted_valid,
	                                                  // evicted_page, all_pinned
);
	import pbcr_pkg::*;

	state_t state_q, state_nx;

	logic [CFG_W-1:0] fiu_q;
	logic [CNT_W-1:0] n;
	logic [IDX_W-1:0] last_idx;
	logic [NUM_FRAMES-1:0] vld_q;
	logic vld_rd_q;

	logic [PAGE_BITS-1:0] page_q;
	logic [REL_W-1:0] rel_q;
	logic [IDX_W-1:0] idx_q, hand_q;
	logic [STEP_W-1:0] steps_q;

	logic [OUT_RAW_W-1:0] res_q;
	logic [OUT_RAW_W-1:0] m_data_q;
	logic out_valid_q;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	entry_t wentry, ram_rd, cur;
	logic [ENTRY_W-1:0] ram_rdata;

	logic match, victim;
	logic [STEP_W-1:0] two_n_m1;
	logic rel_ok;

	// clamp active frame count
	always_comb begin
		if (fiu_q == '0) begin
			n = CNT_W'(1);
		end else if (CNT_W'(fiu_q) > CNT_W'(NUM_FRAMES)) begin
			n = CNT_W'(NUM_FRAMES);
		end else begin
			n = CNT_W'(fiu_q);
		end
	end
	assign last_idx = IDX_W'(n - CNT_W'(1));
	assign two_n_m1 = {n, 1'b0} - STEP_W'(1);
	assign rel_ok = 32'(rel_q) < 32'(NUM_FRAMES);

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = OUT_DATA_W'(m_data_q);

	// frame memory
	pbcr_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_FRAMES)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign ram_rd = entry_t'(ram_rdata);
	assign cur = vld_rd_q ? ram_rd : '0;
	assign match = cur.assigned && (cur.tag == page_q);
	assign victim = (cur.pin == '0) && !cur.mark;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nx = (s_tuser == MODE_RELEASE) ? ST_RREAD : ST_LREAD;
				end
			end
			ST_LREAD: state_nx = ST_LEVAL;
			ST_LEVAL: begin
				if (match) begin
					state_nx = ST_OUT;
				end else if (idx_q == last_idx) begin
					state_nx = ST_SREAD;
				end else begin
					state_nx = ST_LREAD;
				end
			end
			ST_SREAD: state_nx = ST_SEVAL;
			ST_SEVAL: begin
				if (victim || steps_q == two_n_m1) begin
					state_nx = ST_OUT;
				end else begin
					state_nx = ST_SREAD;
				end
			end
			ST_RREAD: state_nx = ST_REVAL;
			ST_REVAL: state_nx = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		wentry = cur;
		raddr = idx_q;
		waddr = idx_q;
		case (state_q)
			ST_LREAD: raddr = idx_q;
			ST_LEVAL: begin
				waddr = idx_q;
				if (match) begin
					we = 1'b1;
					wentry.mark = 1'b1;
					if (cur.pin != PIN_MAX) begin
						wentry.pin = cur.pin + PIN_BITS'(1);
					end
				end
			end
			ST_SREAD: raddr = hand_q;
			ST_SEVAL: begin
				waddr = hand_q;
				if (victim) begin
					we = 1'b1;
					wentry.tag = page_q;
					wentry.assigned = 1'b1;
					wentry.pin = PIN_BITS'(1);
					wentry.mark = 1'b1;
				end else if (cur.pin == '0) begin
					we = 1'b1;
					wentry.mark = 1'b0;
				end
			end
			ST_RREAD: raddr = IDX_W'(rel_q);
			ST_REVAL: begin
				waddr = IDX_W'(rel_q);
				if (rel_ok && cur.pin != '0) begin
					we = 1'b1;
					wentry.pin = cur.pin - PIN_BITS'(1);
				end
			end
			default: ;
		endcase
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fiu_q <= CFG_W'(NUM_FRAMES);
			vld_q <= '0;
			vld_rd_q <= 1'b0;
			hand_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			steps_q <= '0;
		end else begin
			state_q <= state_nx;
			vld_rd_q <= vld_q[raddr];
			if (cfg_valid) begin
				fiu_q <= cfg_data;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_OUT && state_nx == ST_IDLE) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: idx_q <= '0;
				ST_LEVAL: begin
					if (!match && idx_q == last_idx) begin
						// start sweep, restart hand outside active frames
						steps_q <= '0;
						if (CNT_W'(hand_q) >= n) begin
							hand_q <= '0;
						end
					end
					idx_q <= idx_q + IDX_W'(1);
				end
				ST_SEVAL: begin
					if (!victim) begin
						steps_q <= steps_q + STEP_W'(1);
						hand_q <= (hand_q == last_idx) ? '0 : hand_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// capture word and results
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			page_q <= s_tdata[PAGE_BITS-1:0];
			rel_q <= s_tdata[PAGE_BITS +: REL_W];
		end
		// hand the finished result to the output register
		if (state_q == ST_OUT && state_nx == ST_IDLE) begin
			m_data_q <= res_q;
		end
		case (state_q)
			ST_LEVAL: begin
				if (match) begin
					res_q <= {1'b0, PAGE_BITS'(0), 1'b0, 1'b1, OIDX_W'(idx_q)};
				end
			end
			ST_SEVAL: begin
				if (victim) begin
					res_q <= {1'b0, (cur.assigned ? cur.tag : PAGE_BITS'(0)),
						cur.assigned, 1'b0, OIDX_W'(hand_q)};
				end else if (steps_q == two_n_m1) begin
					res_q <= {1'b1, PAGE_BITS'(0), 1'b0, 1'b0, OIDX_W'(0)};
				end
			end
			ST_REVAL: res_q <= {1'b0, PAGE_BITS'(0), 1'b0, 1'b0, OIDX_W'(rel_q)};
			default: ;
		endcase
	end

	a_lookup_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LEVAL |-> CNT_W'(idx_q) < n)
		else $error("lookup index beyond active frames");
	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEVAL |-> CNT_W'(hand_q) < n)
		else $error("clock hand beyond active frames");
	a_write_eval: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_LEVAL || state_q == ST_SEVAL || state_q == ST_REVAL))
		else $error("frame write outside an evaluate step");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && state_nx == ST_IDLE) |=> out_valid_q)
		else $error("result not presented");

endmodule

// File: design/pbcr_ram.sv
module pbcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
